// ===== rtl/core/pru_pkg.sv =====
// Shared types and constants for the pixel replicating upscaler.
package pru_pkg;

  localparam int DEF_MAX_WIDTH = 2048;
  localparam int DEF_MAX_SCALE = 60;

  localparam int PIX_W   = 24;
  localparam int SCALE_W = 6;
  localparam int WIDTH_W = 12;
  localparam int PAD_W   = 2;
  localparam int IDX_W   = 2;

  // item kinds on the input tuser bit
  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_SCALE = 2'd0;
  localparam logic [IDX_W-1:0] REG_WIDTH = 2'd1;

  // one accepted item as handed from control to the result expander
  typedef struct packed {
    logic               mis;
    logic               use_mem;
    logic [PIX_W-1:0]   pix;
    logic [SCALE_W-1:0] npix;
    logic [PAD_W-1:0]   npad;
  } job_t;

endpackage

// ===== rtl/core/pru_line_buf.sv =====
// Line buffer: one write port, one read port with registered read data.
module pru_line_buf
  import pru_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [CW-1:0]    waddr,
  input  logic [PIX_W-1:0] wdata,
  input  logic             re,
  input  logic [CW-1:0]    raddr,
  output logic [PIX_W-1:0] rdata
);

  logic [PIX_W-1:0] mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/pru_ctrl.sv =====
// Row and pass tracking, configuration registers and line buffer access.
module pru_ctrl
  import pru_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int MAX_SCALE = DEF_MAX_SCALE,
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic               s_tuser,
  input  logic [PIX_W-1:0]   s_tdata,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [WIDTH_W-1:0] cfg_data,
  output logic               mem_we,
  output logic               mem_re,
  output logic [CW-1:0]      mem_addr,
  output logic [PIX_W-1:0]   mem_wdata,
  output logic               job_valid,
  output job_t               job,
  input  logic               job_take
);

  localparam int XW = (CW + 1 > WIDTH_W + 1) ? CW + 1 : WIDTH_W + 1;

  logic [SCALE_W-1:0] scale;
  logic [WIDTH_W-1:0] row_width;
  logic [CW-1:0]      col;
  logic [SCALE_W-1:0] pass;

  logic [SCALE_W-1:0] s_eff;
  logic [XW-1:0]      rw_x;
  logic [XW-1:0]      w_eff;
  logic               end_pass;
  logic               end_row;
  logic [3:0]         pad_prod;
  logic               is_pix;
  logic               mis;
  logic               s_fire;
  job_t               job_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale     <= SCALE_W'(1);
      row_width <= WIDTH_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SCALE: scale     <= cfg_data[SCALE_W-1:0];
        REG_WIDTH: row_width <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (scale == '0) s_eff = SCALE_W'(1);
    else if (scale > SCALE_W'(MAX_SCALE)) s_eff = SCALE_W'(MAX_SCALE);
    else s_eff = scale;
  end

  assign rw_x = XW'(row_width);

  always_comb begin
    if (rw_x == '0) w_eff = XW'(1);
    else if (rw_x > XW'(MAX_WIDTH)) w_eff = XW'(MAX_WIDTH);
    else w_eff = rw_x;
  end

  assign end_pass = (XW'(col) + XW'(1)) >= w_eff;
  assign end_row  = ({1'b0, pass} + 7'd1) >= {1'b0, s_eff};
  // bytes per output row mod 4: 3*w*s, so padding is (w*s) mod 4
  assign pad_prod = {2'b00, w_eff[1:0]} * {2'b00, s_eff[1:0]};

  assign is_pix   = (s_tuser == ACT_PIXEL);
  assign mis      = is_pix != (pass == '0);
  assign s_tready = !job_valid || job_take;
  assign s_fire   = s_tvalid && s_tready;

  assign mem_we    = s_fire && !mis && is_pix;
  assign mem_re    = s_fire && !mis && !is_pix;
  assign mem_addr  = col;
  assign mem_wdata = s_tdata;

  always_comb begin
    job_next.mis     = mis;
    job_next.use_mem = !is_pix;
    job_next.pix     = s_tdata;
    job_next.npix    = mis ? '0 : s_eff;
    job_next.npad    = (mis || !end_pass) ? '0 : pad_prod[1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      pass      <= '0;
      job_valid <= 1'b0;
    end else begin
      if (s_fire) begin
        job_valid <= 1'b1;
      end else if (job_take) begin
        job_valid <= 1'b0;
      end
      if (s_fire && !mis) begin
        if (end_pass) begin
          col  <= '0;
          pass <= end_row ? '0 : pass + SCALE_W'(1);
        end else begin
          col  <= col + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      job <= job_next;
    end
  end

  a_job_hold: assert property (@(posedge clk) disable iff (rst)
    job_valid && !job_take |=> job_valid && $stable(job))
    else $error("pending job changed before it was taken");

  a_mis_empty: assert property (@(posedge clk) disable iff (rst)
    job_valid && job.mis |-> job.npix == '0 && job.npad == '0)
    else $error("misordered job carries pixel or padding beats");

  a_pix_count: assert property (@(posedge clk) disable iff (rst)
    job_valid && !job.mis |-> job.npix != '0)
    else $error("accepted item has no pixel beats");

endmodule

// ===== rtl/core/pru_emit.sv =====
// Result expander: turns one job into its pixel, padding or error beats.
module pru_emit
  import pru_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             job_valid,
  input  job_t             job,
  output logic             job_take,
  input  logic [PIX_W-1:0] mem_rdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [PIX_W-1:0] m_tdata,
  output logic [1:0]       m_tuser,
  output logic             m_tlast
);

  logic               busy;
  logic [PIX_W-1:0]   pix;
  logic [SCALE_W-1:0] npix;
  logic [PAD_W-1:0]   npad;
  logic               mis;

  logic beat_pad;
  logic beat_last;
  logic out_fire;
  logic free;

  assign beat_pad  = !mis && (npix == '0);
  assign beat_last = mis
                  || (npix == SCALE_W'(1) && npad == '0)
                  || (npix == '0 && npad == PAD_W'(1));
  assign out_fire  = busy && m_tready;
  assign free      = !busy || (out_fire && beat_last);
  assign job_take  = job_valid && free;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (free) begin
      busy <= job_valid;
    end
  end

  // load a new job when idle or on the current job's last beat; otherwise count beats down
  always_ff @(posedge clk) begin
    if (free) begin
      pix  <= job.use_mem ? mem_rdata : job.pix;
      npix <= job.npix;
      npad <= job.npad;
      mis  <= job.mis;
    end else if (out_fire) begin
      if (npix != '0) begin
        npix <= npix - SCALE_W'(1);
      end else begin
        npad <= npad - PAD_W'(1);
      end
    end
  end

  assign m_tvalid = busy;
  assign m_tdata  = (mis || beat_pad) ? '0 : pix;
  assign m_tuser  = {mis, beat_pad};
  assign m_tlast  = beat_last;

  a_beats_left: assert property (@(posedge clk) disable iff (rst)
    busy && !mis |-> (npix != '0 || npad != '0))
    else $error("expander active with no beats left");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    busy && (beat_pad || mis) |-> m_tdata == '0)
    else $error("padding or error beat carries pixel data");

  a_mis_single: assert property (@(posedge clk) disable iff (rst)
    busy && mis |-> m_tlast && !beat_pad)
    else $error("misordered result is not a single last beat");

endmodule

// ===== rtl/core/pixel_replicating_upscaler_top.sv =====
// Integer nearest-neighbor upscaler for 24-bit pixel rows.
// An accepted item is held as a job until the result expander is free, then loaded into it.
// Throughput: one item per cycle when each item yields one beat and m_tready stays high; otherwise an
// item takes scale_factor beats plus up to three padding beats at the end of a pass, throttled by m_tready.
// Replay reads come from the line buffer, one read per correctly ordered tick item, with registered read data.
// Reset (rst, synchronous) clears row and pass position and sets scale_factor and row_width to 1.
module pixel_replicating_upscaler_top
  import pru_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int MAX_SCALE = DEF_MAX_SCALE
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [PIX_W-1:0]   s_tdata,   // blue[7:0], green[15:8], red[23:16]
  input  logic               s_tuser,   // action
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [PIX_W-1:0]   m_tdata,   // out_blue[7:0], out_green[15:8], out_red[23:16]
  output logic [1:0]         m_tuser,   // is_padding[0], misordered[1]
  output logic               m_tlast,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [WIDTH_W-1:0] cfg_data
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic             mem_we;
  logic             mem_re;
  logic [CW-1:0]    mem_addr;
  logic [PIX_W-1:0] mem_wdata;
  logic [PIX_W-1:0] mem_rdata;
  logic             job_valid;
  job_t             job;
  logic             job_take;

  pru_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_SCALE (MAX_SCALE)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mem_we    (mem_we),
    .mem_re    (mem_re),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .job_valid (job_valid),
    .job       (job),
    .job_take  (job_take)
  );

  pru_line_buf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_buf (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_addr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_addr),
    .rdata (mem_rdata)
  );

  pru_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job),
    .job_take  (job_take),
    .mem_rdata (mem_rdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule
